// File: rtl/core/hce_pkg.sv
package hce_pkg;

    // Width of the chunk size register.
    localparam int CFG_W = 6;
    localparam logic [CFG_W-1:0] CHUNK_SIZE_RESET = 6'd32;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HEX_HI,
        S_HEX_LO,
        S_CR1,
        S_LF1,
        S_DATA,
        S_CR2,
        S_LF2,
        S_ZERO,
        S_ZCR1,
        S_ZLF1,
        S_ZCR2,
        S_ZLF2
    } t_state;

    typedef enum logic [2:0] {
        SEL_HEX_HI,
        SEL_HEX_LO,
        SEL_CR,
        SEL_LF,
        SEL_DATA,
        SEL_ZERO
    } t_byte_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      append;
        logic      close;
        logic      idx_inc;
        logic      emit;
        t_byte_sel sel;
        logic      last;
        logic      msg_end;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic append_fills;
        logic fill_zero;
        logic cnt_hi_nz;
        logic idx_last;
        logic out_free;
    } t_dp_status;

    // Lowercase hexadecimal character for one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: rtl/core/http_chunked_encoder_core.sv
// HTTP chunked transfer encoder.
// Input channel (i_in_valid / o_in_stall) carries one item per body byte:
// i_func = 0 appends i_data_byte to the chunk buffer, i_func = 1 closes the
// message. Output channel (o_out_valid / i_out_stall) carries one item per
// byte of the chunked stream, with o_run_last on the final byte caused by
// an input item and o_message_end on the last LF of the zero chunk.
// i_cfg_we writes the chunk size (1..BUFFER_DEPTH; zero acts as one, larger
// values saturate). Write it only while the block is idle.
// An append that does not complete a chunk leaves the input unstalled. An
// append that completes a chunk of n bytes holds the input stalled while
// the controller walks the hex count, CR LF, the buffered bytes and CR LF,
// one byte per cycle through the single output register unless the output
// stalls. A close sends the terminating chunk after any partial chunk.
// The buffer is a single-port-write memory read one byte per cycle.
// Synchronous reset empties the buffer count, sets the chunk size to 32 and
// drops o_out_valid; no clearing pass is needed. A stall on the output
// freezes the output register and any emitting sequencer state until taken.
module http_chunked_encoder_core
    import hce_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic [7:0]       i_data_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_message_end,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Controller: sequences the framing and data bytes of each chunk.
    hce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // Datapath: buffer memory, counters, chunk size and output register.
    hce_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data_byte   (i_data_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

endmodule

// File: rtl/core/hce_ctrl.sv
module hce_ctrl
    import hce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_func,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;
    logic   r_close;
    logic   n_close;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign n_close    = accept ? i_func : r_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_close <= 1'b0;
        end else begin
            r_state <= n_state;
            r_close <= n_close;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_func) begin
                        n_state = i_status.fill_zero ? S_ZERO : S_HEX_HI;
                    end else if (i_status.append_fills) begin
                        n_state = S_HEX_HI;
                    end
                end
            end
            S_HEX_HI: begin
                if (!i_status.cnt_hi_nz || i_status.out_free) begin
                    n_state = S_HEX_LO;
                end
            end
            S_HEX_LO: if (i_status.out_free) n_state = S_CR1;
            S_CR1:    if (i_status.out_free) n_state = S_LF1;
            S_LF1:    if (i_status.out_free) n_state = S_DATA;
            S_DATA: begin
                if (i_status.out_free && i_status.idx_last) begin
                    n_state = S_CR2;
                end
            end
            S_CR2:    if (i_status.out_free) n_state = S_LF2;
            S_LF2: begin
                if (i_status.out_free) begin
                    n_state = r_close ? S_ZERO : S_IDLE;
                end
            end
            S_ZERO:   if (i_status.out_free) n_state = S_ZCR1;
            S_ZCR1:   if (i_status.out_free) n_state = S_ZLF1;
            S_ZLF1:   if (i_status.out_free) n_state = S_ZCR2;
            S_ZCR2:   if (i_status.out_free) n_state = S_ZLF2;
            S_ZLF2:   if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd         = '0;
        o_cmd.sel     = SEL_CR;
        case (r_state)
            S_IDLE: begin
                o_cmd.append = accept && !i_func;
                o_cmd.close  = accept && i_func;
            end
            S_HEX_HI: begin
                o_cmd.emit = i_status.out_free && i_status.cnt_hi_nz;
                o_cmd.sel  = SEL_HEX_HI;
            end
            S_HEX_LO: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_HEX_LO;
            end
            S_CR1, S_CR2, S_ZCR1, S_ZCR2: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_CR;
            end
            S_LF1, S_ZLF1: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_LF;
            end
            S_DATA: begin
                o_cmd.emit    = i_status.out_free;
                o_cmd.sel     = SEL_DATA;
                o_cmd.idx_inc = i_status.out_free && !i_status.idx_last;
            end
            S_LF2: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_LF;
                o_cmd.last = !r_close;
            end
            S_ZERO: begin
                o_cmd.emit = i_status.out_free;
                o_cmd.sel  = SEL_ZERO;
            end
            S_ZLF2: begin
                o_cmd.emit    = i_status.out_free;
                o_cmd.sel     = SEL_LF;
                o_cmd.last    = 1'b1;
                o_cmd.msg_end = 1'b1;
            end
            default: begin
                o_cmd.emit = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/hce_datapath.sv
module hce_datapath
    import hce_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_status,
    input  logic [7:0]       i_data_byte,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_run_last,
    output logic             o_message_end
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
    localparam logic [CFG_W-1:0] DEPTH_CFG = CFG_W'(BUFFER_DEPTH);

    logic [7:0]       mem [0:BUFFER_DEPTH-1];
    logic [7:0]       r_rd_data;

    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CFG_W-1:0] r_chunk_size, n_chunk_size;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_run_last;
    logic             r_message_end;

    logic [CNT_W-1:0] fill_inc;
    logic [CFG_W-1:0] eff_size;
    logic [CFG_W-1:0] cnt_ext;
    logic             fill_room;
    logic [7:0]       sel_byte;

    assign fill_room = (r_fill < DEPTH_C);
    assign fill_inc  = fill_room ? CNT_W'(r_fill + CNT_W'(1)) : r_fill;
    assign cnt_ext   = CFG_W'(r_cnt);

    // A size of zero acts as one; sizes past the buffer saturate.
    always_comb begin
        if (r_chunk_size == '0) begin
            eff_size = CFG_W'(1);
        end else if (r_chunk_size > DEPTH_CFG) begin
            eff_size = DEPTH_CFG;
        end else begin
            eff_size = r_chunk_size;
        end
    end

    assign o_status.append_fills = (CFG_W'(fill_inc) >= eff_size);
    assign o_status.fill_zero    = (r_fill == '0);
    assign o_status.cnt_hi_nz    = (cnt_ext[5:4] != 2'd0);
    assign o_status.idx_last     = (CNT_W'(r_idx) == CNT_W'(r_cnt - CNT_W'(1)));
    assign o_status.out_free     = !r_out_valid || !i_out_stall;

    always_comb begin
        n_fill       = r_fill;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_chunk_size = i_cfg_we ? i_cfg_data : r_chunk_size;
        if (i_cmd.append) begin
            n_idx = '0;
            if (o_status.append_fills) begin
                n_cnt  = fill_inc;
                n_fill = '0;
            end else begin
                n_fill = fill_inc;
            end
        end else if (i_cmd.close) begin
            n_idx  = '0;
            n_cnt  = r_fill;
            n_fill = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = IDX_W'(r_idx + IDX_W'(1));
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        case (i_cmd.sel)
            SEL_HEX_HI: sel_byte = hex_char({2'b00, cnt_ext[5:4]});
            SEL_HEX_LO: sel_byte = hex_char(cnt_ext[3:0]);
            SEL_CR:     sel_byte = CHAR_CR;
            SEL_LF:     sel_byte = CHAR_LF;
            SEL_DATA:   sel_byte = r_rd_data;
            SEL_ZERO:   sel_byte = CHAR_ZERO;
            default:    sel_byte = CHAR_CR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_chunk_size <= CHUNK_SIZE_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_cnt        <= n_cnt;
            r_idx        <= n_idx;
            r_chunk_size <= n_chunk_size;
            r_out_valid  <= n_out_valid;
        end
    end

    // Buffer memory; the read port follows the next index every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && fill_room) begin
            mem[r_fill[IDX_W-1:0]] <= i_data_byte;
        end
        r_rd_data <= mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte    <= sel_byte;
            r_run_last    <= i_cmd.last;
            r_message_end <= i_cmd.msg_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_message_end = r_message_end;

`ifndef SYNTHESIS
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_message_end) |-> r_run_last)
        else $error("message end without run last");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    a_close_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.close |=> (r_fill == '0))
        else $error("buffer not empty after close");
`endif

endmodule

// File: tb/http_chunked_encoder_core_tb.sv
`timescale 1ns / 1ps

module http_chunked_encoder_core_tb;
    import hce_pkg::*;

    // The buffer depth matches the default of the block.
    localparam int BUFFER_DEPTH = 32;

    // An append that completes no chunk is absorbed without stalling the input.
    // The settle period is therefore ample before the chunk size is touched.
    localparam int SETTLE_CYCLES = 10;

    // Length of the long receiver hold-off. It must be far longer than one chunk
    // takes, so that the output register fills and the input stalls behind it.
    localparam int HOLD_CYCLES = 300;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int PRESSURE_PHASE  = 4;

    localparam logic [7:0] ASCII_CR      = 8'h0D;
    localparam logic [7:0] ASCII_LF      = 8'h0A;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_CLOSE  = 1'b1
    } t_body_op;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    // One body item as it travels on the input channel.
    typedef struct {
        t_body_op   op;
        logic [7:0] data;
    } t_body_item;

    // One byte of the chunked stream together with its side flags.
    typedef struct {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_stream_byte;

    // The random part walks these chunk sizes. Zero and 63 are the extremes of the
    // register: zero acts as one and 63 saturates to the buffer depth.
    localparam int PHASE_SIZE [NUM_PHASES] = '{32, 1, 63, 17, 5, 0, 12, 32};
    localparam t_idle_mode PHASE_IDLING [NUM_PHASES] = '{
        IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
        IDLE_NONE, IDLE_BOTH, IDLE_SENDER, IDLE_RECEIVER
    };

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_func = 1'b0;
    logic [7:0]       i_data_byte = 8'h00;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_out_byte;
    logic             o_run_last;
    logic             o_message_end;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    http_chunked_encoder_core #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // Items waiting to be offered, and the stream bytes the encoder still owes us.
    t_body_item   pending_items [$];
    t_stream_byte expected_stream [$];

    // Our own copy of the encoder state: the held body bytes, how many there are,
    // and the chunk size register as last written.
    logic [7:0]       held_bytes [BUFFER_DEPTH];
    int               held_count = 0;
    logic [CFG_W-1:0] chunk_size_copy = CHUNK_SIZE_RESET;

    // Idling percentages for the two sides; the hold-off runs on top of them.
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic receiver_hold = 1'b0;
    logic pressure_go = 1'b0;

    int fail_count = 0;
    int items_sent = 0;
    int bytes_checked = 0;
    int chunks_framed = 0;
    int messages_ended = 0;
    int cfg_writes = 0;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction of the chunked stream
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? ASCII_ZERO + {4'd0, nib} : ASCII_LOWER_A + {4'd0, nib} - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] ch, input logic msg_end);
        t_stream_byte sb;
        sb.ch       = ch;
        sb.run_last = 1'b0;
        sb.msg_end  = msg_end;
        expected_stream.push_back(sb);
    endtask

    // Frames whatever is held as one chunk: hex count without leading zeros, CR LF,
    // the body bytes in arrival order, CR LF. An empty buffer frames nothing.
    task automatic frame_held_bytes();
        logic [5:0] n;
        n = held_count[5:0];
        if (held_count == 0) begin
            return;
        end
        if (n[5:4] != 2'd0) begin
            push_byte(hex_ascii({2'b00, n[5:4]}), 1'b0);
        end
        push_byte(hex_ascii(n[3:0]), 1'b0);
        push_byte(ASCII_CR, 1'b0);
        push_byte(ASCII_LF, 1'b0);
        for (int i = 0; i < held_count; i++) begin
            push_byte(held_bytes[i], 1'b0);
        end
        push_byte(ASCII_CR, 1'b0);
        push_byte(ASCII_LF, 1'b0);
        held_count = 0;
        chunks_framed++;
    endtask

    // Works out every stream byte that one accepted body item causes.
    task automatic encode_item(input t_body_item item);
        int prior_len;
        int limit;
        prior_len = expected_stream.size();
        // A chunk size of zero acts as one; anything above the depth saturates.
        limit = (chunk_size_copy == '0) ? 1 :
                (chunk_size_copy > BUFFER_DEPTH) ? BUFFER_DEPTH : int'(chunk_size_copy);
        if (item.op == OP_APPEND) begin
            if (held_count < BUFFER_DEPTH) begin
                held_bytes[held_count] = item.data;
                held_count++;
            end
            // After the size was lowered the held count may already exceed the
            // limit; the next append then sends everything as one chunk.
            if (held_count >= limit) begin
                frame_held_bytes();
            end
        end else begin
            // Close: flush a partial chunk, then the terminating zero chunk.
            frame_held_bytes();
            push_byte(ASCII_ZERO, 1'b0);
            push_byte(ASCII_CR, 1'b0);
            push_byte(ASCII_LF, 1'b0);
            push_byte(ASCII_CR, 1'b0);
            push_byte(ASCII_LF, 1'b1);
        end
        if (expected_stream.size() > prior_len) begin
            expected_stream[expected_stream.size() - 1].run_last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    // An item is taken at an edge where valid is high and stall is low. The item is
    // predicted at that edge, and the next one is offered, or the channel idles at
    // random. A stalled item stays put with its payload unchanged.
    always @(posedge i_clk) begin : drive_items
        t_body_item accepted;
        t_body_item queued;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) begin
                accepted.op   = t_body_op'(i_func);
                accepted.data = i_data_byte;
                encode_item(accepted);
                items_sent++;
            end
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                queued = pending_items.pop_front();
                i_in_valid  <= 1'b1;
                i_func      <= queued.op;
                i_data_byte <= queued.data;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor
    // ------------------------------------------------------------------

    // Every stream byte taken is checked field by field against the oldest
    // expectation. The stall for the next cycle is drawn here too; the long
    // hold-off forces it high regardless of the random draw.
    always @(posedge i_clk) begin : check_stream
        t_stream_byte want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_stream.size() == 0) begin
                    $display("%0t: unexpected stream byte, expected none, got 8'h%02h",
                             $time, o_out_byte);
                    fail_count++;
                end else begin
                    want = expected_stream.pop_front();
                    bytes_checked++;
                    if (o_out_byte !== want.ch) begin
                        $display("%0t: out_byte expected 8'h%02h, got 8'h%02h",
                                 $time, want.ch, o_out_byte);
                        fail_count++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $display("%0t: run_last expected %0b, got %0b",
                                 $time, want.run_last, o_run_last);
                        fail_count++;
                    end
                    if (o_message_end !== want.msg_end) begin
                        $display("%0t: message_end expected %0b, got %0b",
                                 $time, want.msg_end, o_message_end);
                        fail_count++;
                    end
                    if (want.msg_end) begin
                        messages_ended++;
                    end
                end
            end
            i_out_stall <= receiver_hold || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // The long hold-off counts its own cycles. While it lasts the sender keeps
    // offering, so the encoder must fill its output and push back on the input.
    initial begin : receiver_holdoff
        wait (pressure_go);
        @(posedge i_clk);
        receiver_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        receiver_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Items are queued at the falling edge so the driver never races the push.
    task automatic queue_item(input t_body_op op, input logic [7:0] data);
        t_body_item item;
        item.op   = op;
        item.data = data;
        pending_items.push_back(item);
    endtask

    // Waits until every item has gone in and every predicted byte has come out,
    // then waits out the settle period in case the last append is still being absorbed.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || i_in_valid || expected_stream.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_chunk_size(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        chunk_size_copy = value;
        cfg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct = (mode == IDLE_SENDER) ? 77 : (mode == IDLE_BOTH) ? 20 : 0;
        stall_pct     = (mode == IDLE_RECEIVER) ? 77 : (mode == IDLE_BOTH) ? 20 : 0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        int close_pct;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idling(IDLE_NONE);

        // Reset chunk size of 32: extreme byte values, a partial chunk flushed by
        // a close, and then a close with nothing held.
        queue_item(OP_APPEND, 8'h00);
        queue_item(OP_APPEND, 8'hFF);
        queue_item(OP_APPEND, 8'h55);
        queue_item(OP_APPEND, 8'hAA);
        queue_item(OP_CLOSE, 8'h00);
        queue_item(OP_CLOSE, 8'hFF);
        wait_idle();

        // A chunk size of zero behaves as one: every byte is its own chunk.
        write_chunk_size(6'd0);
        queue_item(OP_APPEND, 8'h00);
        queue_item(OP_APPEND, 8'hFF);
        queue_item(OP_CLOSE, 8'h00);
        wait_idle();

        // Lower the size while five bytes are held; the next append sends all six.
        write_chunk_size(6'd8);
        queue_item(OP_APPEND, 8'h01);
        queue_item(OP_APPEND, 8'h80);
        queue_item(OP_APPEND, 8'h7F);
        queue_item(OP_APPEND, 8'hFE);
        queue_item(OP_APPEND, 8'h10);
        wait_idle();
        write_chunk_size(6'd3);
        queue_item(OP_APPEND, 8'h42);
        queue_item(OP_CLOSE, 8'h00);
        wait_idle();

        // The largest register value saturates to the buffer depth.
        write_chunk_size(6'd63);
        queue_item(OP_APPEND, 8'h33);
        queue_item(OP_APPEND, 8'hCC);
        queue_item(OP_CLOSE, 8'h00);
        wait_idle();

        // Random messages: mostly body bytes with an occasional close, each phase
        // under its own chunk size and idling pattern and ending with a close.
        // Large chunk sizes get fewer closes so that full chunks still form.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_chunk_size(CFG_W'(PHASE_SIZE[p]));
            set_idling(PHASE_IDLING[p]);
            close_pct = (PHASE_SIZE[p] > 16) ? 3 : 12;
            if (p == PRESSURE_PHASE) begin
                pressure_go = 1'b1;
            end
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 99) < close_pct) begin
                    queue_item(OP_CLOSE, 8'($urandom_range(0, 255)));
                end else begin
                    queue_item(OP_APPEND, 8'($urandom_range(0, 255)));
                end
            end
            queue_item(OP_CLOSE, 8'($urandom_range(0, 255)));
            wait_idle();
        end

        $display("Sent %0d body items over %0d chunk size writes; %0d chunks and %0d messages.",
                 items_sent, cfg_writes, chunks_framed, messages_ended);
        $display("Checked %0d stream bytes under free flow, random idling and a long hold-off.",
                 bytes_checked);
        if (fail_count == 0 && expected_stream.size() == 0) begin
            $display("http_chunked_encoder_core test passed");
        end else begin
            $display("http_chunked_encoder_core test failed");
        end
        $finish;
    end

    // The timeout leaves a wide margin over a correct run even if every byte
    // sat through long stalls.
    initial begin : watchdog
        #1_000_000;
        $display("Timeout with %0d stream bytes still expected.", expected_stream.size());
        $display("http_chunked_encoder_core test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/hce_pkg.sv
rtl/core/hce_ctrl.sv
rtl/core/hce_datapath.sv
rtl/core/http_chunked_encoder_core.sv
tb/http_chunked_encoder_core_tb.sv
